// ===== rtl/glyph_atlas_shelf_packer_macros.svh =====
// ----------------------------------------------------------------------------
// glyph atlas shelf packer assertion macros
// immediate-free concurrent checks, clocked on clk_i and held off in reset
// ----------------------------------------------------------------------------
`ifndef GLYPH_ATLAS_SHELF_PACKER_MACROS_SVH
`define GLYPH_ATLAS_SHELF_PACKER_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every edge outside reset
`define GASP_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// consequent holds at the next edge after the antecedent
`define GASP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define GASP_ASSERT(name, cond, msg)
`define GASP_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

// ===== rtl/gasp_pkg.sv =====
// ----------------------------------------------------------------------------
// gasp_pkg
// types and fixed field widths for the glyph atlas shelf packer
// ----------------------------------------------------------------------------
`default_nettype none

package gasp_pkg;

  localparam int unsigned RectW      = 12;  // request width/height field
  localparam int unsigned PosW       = 16;  // placement coordinates
  localparam int unsigned SizeW      = 17;  // reported atlas size
  localparam int unsigned InTdataW   = 24;  // rect_width, rect_height
  localparam int unsigned OutTdataW  = 72;  // x, y, width, height, zero pad

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_GROW   = 6'b000010,
    ST_WRAP   = 6'b000100,
    ST_SHELF  = 6'b001000,
    ST_REGION = 6'b010000,
    ST_POST   = 6'b100000
  } gasp_state_e;

endpackage

`default_nettype wire

// ===== rtl/glyph_atlas_shelf_packer.sv =====
// ----------------------------------------------------------------------------
// glyph atlas shelf packer
// places glyph rectangles row by row into a power-of-two atlas that grows
// ----------------------------------------------------------------------------
// usage: one request on the s_axis channel gives one placement on m_axis.
// s_axis_tdata carries rect_width and rect_height, s_axis_tuser the restart
// flag, which clears atlas state before that rectangle is placed.
// m_axis_tdata returns place_x, place_y and the atlas size after placement,
// m_axis_tuser the overflow flag (the atlas would have to grow past 2^MAX_ATLAS_LOG2).
// steps: after acceptance a request runs through a fit step that doubles the
// atlas as often as needed (at most 2*MAX_ATLAS_LOG2 doublings), a wrap step,
// a shelf step only when the pen wraps to a new row, a region and a post step.
// the wrap, shelf, region and post steps run through one shared add-and-compare
// unit under the sequencer, so one request is in work at a time and s_axis_tready
// is low until the sequencer is back in idle; a new request is taken only once
// the previous one has left the post step.
// a finished result sits in the output register; a new request can be
// taken while it waits, and the sequencer stalls in its last step only if
// the receiver has not yet taken the previous result.
// reset sets the atlas to 1x1 with the pen, region and row height at zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "glyph_atlas_shelf_packer_macros.svh"

module glyph_atlas_shelf_packer
  import gasp_pkg::*;
#(
  parameter int unsigned MAX_ATLAS_LOG2 = 16,
  parameter int unsigned RECT_DIM_BITS  = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InTdataW-1:0]  s_axis_tdata,   // rect_width, rect_height
  input  wire logic                 s_axis_tuser,   // restart
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutTdataW-1:0]      m_axis_tdata,   // place_x, place_y,
                                                    // atlas_width, atlas_height
  output logic                      m_axis_tuser    // overflow
);

  localparam int unsigned AW = MAX_ATLAS_LOG2 + 1;
  localparam int unsigned DW = RECT_DIM_BITS;
  localparam int unsigned CW = (AW > PosW + 1) ? AW : PosW + 1;
  localparam logic [AW-1:0] ATLAS_MAX = AW'(1) << MAX_ATLAS_LOG2;

  gasp_state_e state_q, state_d;

  logic [AW-1:0]   cur_w_q, cur_h_q;
  logic [PosW-1:0] region_x_q, region_y_q, pen_x_q, pen_y_q;
  logic [DW-1:0]   shelf_q;
  logic [DW-1:0]   rect_w_q, rect_h_q;
  logic            ovf_q;

  logic                 out_valid_q;
  logic [PosW-1:0]      out_x_q, out_y_q;
  logic [SizeW-1:0]     out_w_q, out_h_q;
  logic                 out_ovf_q;

  logic [DW-1:0]   in_w, in_h;
  logic            in_fire;
  logic            out_free;

  // shared add-and-compare unit
  logic [PosW-1:0] unit_a, unit_b;
  logic [AW-1:0]   unit_c;
  logic [PosW:0]   unit_sum;
  logic            unit_ge;

  logic            grow_need;

  assign in_w     = DW'(s_axis_tdata[RectW-1:0]);
  assign in_h     = DW'(s_axis_tdata[2*RectW-1:RectW]);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    unit_a = '0;
    unit_b = '0;
    unit_c = '0;
    unique case (state_q)
      ST_WRAP: begin
        unit_a = pen_x_q;
        unit_b = PosW'(rect_w_q);
        unit_c = cur_w_q;
      end
      ST_SHELF: begin
        unit_a = pen_y_q;
        unit_b = PosW'(shelf_q);
      end
      ST_REGION: begin
        unit_a = pen_y_q;
        unit_b = PosW'(rect_h_q);
        unit_c = cur_h_q;
      end
      ST_POST: begin
        unit_a = pen_x_q;
        unit_b = PosW'(rect_w_q);
      end
      default: begin
        unit_a = '0;
      end
    endcase
  end

  assign unit_sum = {1'b0, unit_a} + {1'b0, unit_b};
  assign unit_ge  = CW'(unit_sum) >= CW'(unit_c);

  // rectangle must be strictly smaller than the atlas in both axes
  assign grow_need = (CW'(rect_w_q) >= CW'(cur_w_q)) || (CW'(rect_h_q) >= CW'(cur_h_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_GROW;
      ST_GROW: begin
        if (!grow_need) begin
          state_d = ST_WRAP;
        end else if (cur_w_q != cur_h_q) begin
          if (cur_w_q == ATLAS_MAX) state_d = ST_WRAP;
        end else if (cur_h_q == ATLAS_MAX) begin
          state_d = ST_WRAP;
        end
      end
      ST_WRAP:   state_d = unit_ge ? ST_SHELF : ST_REGION;
      ST_SHELF:  state_d = ST_REGION;
      ST_REGION: state_d = ST_POST;
      ST_POST:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_w_q     <= AW'(1);
      cur_h_q     <= AW'(1);
      region_x_q  <= '0;
      region_y_q  <= '0;
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      shelf_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_POST && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            ovf_q <= 1'b0;
            if (s_axis_tuser) begin
              cur_w_q    <= AW'(1);
              cur_h_q    <= AW'(1);
              region_x_q <= '0;
              region_y_q <= '0;
              pen_x_q    <= '0;
              pen_y_q    <= '0;
              shelf_q    <= '0;
            end
          end
        end
        ST_GROW: begin
          if (grow_need) begin
            // width doubles when not square, height when square
            if (cur_w_q != cur_h_q) begin
              if (cur_w_q == ATLAS_MAX) ovf_q <= 1'b1;
              else cur_w_q <= cur_w_q << 1;
            end else begin
              if (cur_h_q == ATLAS_MAX) ovf_q <= 1'b1;
              else cur_h_q <= cur_h_q << 1;
            end
          end
        end
        ST_WRAP: begin
          if (unit_ge) pen_x_q <= region_x_q;
        end
        ST_SHELF: begin
          pen_y_q <= unit_sum[PosW-1:0];
          shelf_q <= '0;
        end
        ST_REGION: begin
          if (unit_ge) begin
            if (cur_w_q == cur_h_q) begin
              if (cur_w_q == ATLAS_MAX) begin
                ovf_q   <= 1'b1;
                pen_x_q <= region_x_q;
                pen_y_q <= region_y_q;
              end else begin
                region_x_q <= PosW'(cur_w_q);
                region_y_q <= '0;
                pen_x_q    <= PosW'(cur_w_q);
                pen_y_q    <= '0;
                cur_w_q    <= cur_w_q << 1;
              end
            end else begin
              if (cur_h_q == ATLAS_MAX) begin
                ovf_q   <= 1'b1;
                pen_x_q <= region_x_q;
                pen_y_q <= region_y_q;
              end else begin
                region_x_q <= '0;
                region_y_q <= PosW'(cur_h_q);
                pen_x_q    <= '0;
                pen_y_q    <= PosW'(cur_h_q);
                cur_h_q    <= cur_h_q << 1;
              end
            end
          end
        end
        ST_POST: begin
          if (out_free) begin
            if (shelf_q < rect_h_q) shelf_q <= rect_h_q;
            pen_x_q <= unit_sum[PosW-1:0];
          end
        end
        default: begin
          ovf_q <= ovf_q;
        end
      endcase
    end
  end

  // request and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rect_w_q <= in_w;
      rect_h_q <= in_h;
    end
    if (state_q == ST_POST && out_free) begin
      out_x_q   <= pen_x_q;
      out_y_q   <= pen_y_q;
      out_w_q   <= SizeW'(cur_w_q);
      out_h_q   <= SizeW'(cur_h_q);
      out_ovf_q <= ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ovf_q;
  assign m_axis_tdata  = OutTdataW'({out_h_q, out_w_q, out_y_q, out_x_q});

  `GASP_ASSERT(a_atlas_pow2, $onehot(cur_w_q) && $onehot(cur_h_q), "atlas size not a power of two")
  `GASP_ASSERT_NEXT(a_accept_grow, s_axis_tvalid && s_axis_tready, state_q == ST_GROW, "request not followed by fit step")
  `GASP_ASSERT(a_result_from_post, $rose(m_axis_tvalid) |-> $past(state_q == ST_POST), "result raised outside final step")

endmodule

`default_nettype wire
